// ===== src/bfp_pkg.sv =====
// ============================================================================
// bfp_pkg - shared types and constants of the bloom filter probe unit
// Store geometry, configuration codes and the request/response groups that
// pass between the controller, the modulo unit and the bit store.
// ============================================================================
package bfp_pkg;

    localparam int HASH_W          = 32;
    localparam int KEY_W           = 32;
    localparam int MAX_FILTER_BITS = 1048576;
    localparam int MAX_PROBES      = 32;

    localparam int FILTER_BITS_W   = 21;
    localparam int HASH_COUNT_W    = 6;
    localparam int PROBE_W         = $clog2(MAX_PROBES);

    // bit index and byte address into the store
    localparam int BIT_IDX_W       = $clog2(MAX_FILTER_BITS);
    localparam int STORE_DEPTH     = (MAX_FILTER_BITS + 7) / 8;
    localparam int ADDR_W          = $clog2(STORE_DEPTH);

    // modulo unit: hash bits retired per cycle and iterations per reduction
    localparam int MOD_STEPS       = 4;
    localparam int MOD_CYCLES      = HASH_W / MOD_STEPS;
    localparam int MOD_CNT_W       = $clog2(MOD_CYCLES);

    // reset values of the configuration registers
    localparam logic [FILTER_BITS_W-1:0] FILTER_BITS_RESET = FILTER_BITS_W'(1048576);
    localparam logic [HASH_COUNT_W-1:0]  HASH_COUNT_RESET  = HASH_COUNT_W'(7);

    // register indexes on the configuration port
    localparam int                 REG_IDX_W       = 1;
    localparam logic [REG_IDX_W-1:0] REG_FILTER_BITS = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_HASH_COUNT  = 1'b1;
    localparam int                 PADDR_W         = 3;

    localparam int IN_DATA_W  = HASH_W;
    localparam int OUT_DATA_W = ((1 + KEY_W + 7) / 8) * 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic                     start;
        logic [HASH_W-1:0]        dividend;
        logic [FILTER_BITS_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic                 done;
        logic [BIT_IDX_W-1:0] remainder;
    } mod_rsp_t;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } store_req_t;

endpackage

// ===== src/bfp_mod.sv =====
// ============================================================================
// bfp_mod - iterative remainder unit
// Restoring remainder of a 32-bit hash by the filter size, several dividend
// bits retired per cycle; done is set at the same edge as the final step.
// ============================================================================
module bfp_mod
(
    input  logic              clk,
    input  logic              rst_n,
    input  bfp_pkg::mod_req_t req,
    output bfp_pkg::mod_rsp_t rsp
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [bfp_pkg::MOD_CNT_W-1:0]       cnt_reg;
    logic [bfp_pkg::HASH_W-1:0]          dvd_reg;
    logic [bfp_pkg::FILTER_BITS_W-1:0]   div_reg;
    logic [bfp_pkg::BIT_IDX_W-1:0]       rem_reg;
    logic [bfp_pkg::BIT_IDX_W-1:0]       rem_next;

    always_comb
    begin
        logic [bfp_pkg::BIT_IDX_W:0] t;
        rem_next = rem_reg;
        for (int i = 0; i < bfp_pkg::MOD_STEPS; i++)
        begin
            t = {rem_next, dvd_reg[bfp_pkg::HASH_W-1-i]};
            if (t >= (bfp_pkg::BIT_IDX_W+1)'(div_reg))
            begin
                t = t - (bfp_pkg::BIT_IDX_W+1)'(div_reg);
            end
            rem_next = t[bfp_pkg::BIT_IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == bfp_pkg::MOD_CNT_W'(bfp_pkg::MOD_CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            div_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << bfp_pkg::MOD_STEPS;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== src/bfp_store.sv =====
// ============================================================================
// bfp_store - filter byte store
// Single-port byte memory with registered read data and a clearing sweep
// that zeroes every byte after reset, one byte per cycle.
// ============================================================================
module bfp_store
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  bfp_pkg::store_req_t          req,
    output logic [7:0]                   rdata,
    output logic                         clear_busy
);

    logic [7:0]                  mem [bfp_pkg::STORE_DEPTH];
    logic [7:0]                  rdata_reg;
    logic                        clearing_reg;
    logic [bfp_pkg::ADDR_W-1:0]  clr_addr_reg;

    logic                        we;
    logic [bfp_pkg::ADDR_W-1:0]  addr;
    logic [7:0]                  wdata;

    // the sweep owns the port until every byte is zero
    assign we    = clearing_reg | req.wr_en;
    assign addr  = clearing_reg ? clr_addr_reg : req.addr;
    assign wdata = clearing_reg ? 8'h00 : req.wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == bfp_pkg::ADDR_W'(bfp_pkg::STORE_DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (req.rd_en && !clearing_reg)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata      = rdata_reg;
    assign clear_busy = clearing_reg;

endmodule

// ===== src/bloom_filter_probe_unit.sv =====
// ============================================================================
// bloom_filter_probe_unit - bloom filter bit store with streamed probes
// ----------------------------------------------------------------------------
// Input channel (s_*): one probe per item, s_tuser = op (0 insert, 1 query),
// s_tdata = 32-bit probe hash. The hash is reduced modulo filter_bits and the
// addressed bit (MSB-first in its byte) is set or tested.
// Output channel (m_*): one result at the last probe of a key (probe number
// hash_count). m_tuser = was_query, m_tdata = found and stored_keys.
// APB port: filter_bits at 0x0, hash_count at 0x4; pready is always high.
// One probe is in flight at a time. The remainder unit retires four hash bits
// per cycle and flags done; the byte is then read, written back in the update
// state for an insert, and the unit returns to idle before it accepts the next
// probe. A result is loaded into the output register in the update state.
// Reset: the store's 131072 bytes are swept to zero, one byte per cycle; no
// probe is accepted meanwhile, configuration writes are taken.
// Stall: a finished result waits in its output register while the next probe
// is accepted and reduced; the probe that ends the following key holds in its
// update cycle until the pending result is taken.
// ============================================================================
module bloom_filter_probe_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bfp_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // probe items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bfp_pkg::IN_DATA_W-1:0]     s_tdata,  // [31:0] hash_value
    input  logic                              s_tuser,  // [0] op
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bfp_pkg::OUT_DATA_W-1:0]    m_tdata,  // [0] found, [32:1] stored_keys
    output logic                              m_tuser   // [0] was_query
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_MOD    = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0]                           state_reg;
    logic [1:0]                           state_next;

    logic [bfp_pkg::FILTER_BITS_W-1:0]    filter_bits_reg;
    logic [bfp_pkg::HASH_COUNT_W-1:0]     hash_count_reg;

    logic [bfp_pkg::PROBE_W-1:0]          probe_index_reg;
    logic                                 any_miss_reg;
    logic [bfp_pkg::KEY_W-1:0]            key_total_reg;
    logic                                 op_reg;
    logic [bfp_pkg::ADDR_W-1:0]           addr_reg;
    logic [2:0]                           bit_reg;

    logic                                 m_tvalid_reg;
    logic                                 was_query_reg;
    logic                                 found_reg;

    logic [bfp_pkg::FILTER_BITS_W-1:0]    used_bits;
    logic [bfp_pkg::HASH_COUNT_W-1:0]     used_probes;

    bfp_pkg::mod_req_t                    mod_req;
    bfp_pkg::mod_rsp_t                    mod_rsp;
    bfp_pkg::store_req_t                  st_req;
    logic [7:0]                           st_rdata;
    logic                                 clear_busy;

    logic                                 s_accept;
    logic                                 cfg_write;
    logic [bfp_pkg::REG_IDX_W-1:0]        cfg_idx;
    logic [7:0]                           mask;
    logic                                 bit_clear;
    logic                                 last;
    logic                                 advance;

    // ---------------------------------------------------------------- config
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_idx   = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_bits_reg <= bfp_pkg::FILTER_BITS_RESET;
            hash_count_reg  <= bfp_pkg::HASH_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                bfp_pkg::REG_FILTER_BITS: filter_bits_reg <= pwdata[bfp_pkg::FILTER_BITS_W-1:0];
                bfp_pkg::REG_HASH_COUNT:  hash_count_reg  <= pwdata[bfp_pkg::HASH_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            bfp_pkg::REG_FILTER_BITS: prdata = 32'(filter_bits_reg);
            bfp_pkg::REG_HASH_COUNT:  prdata = 32'(hash_count_reg);
            default:                  prdata = '0;
        endcase
    end

    // clamp the configured sizes: zero becomes one, maxima are MAX_FILTER_BITS and MAX_PROBES
    always_comb
    begin
        if (filter_bits_reg == '0)
            used_bits = bfp_pkg::FILTER_BITS_W'(1);
        else if (filter_bits_reg > bfp_pkg::FILTER_BITS_W'(bfp_pkg::MAX_FILTER_BITS))
            used_bits = bfp_pkg::FILTER_BITS_W'(bfp_pkg::MAX_FILTER_BITS);
        else
            used_bits = filter_bits_reg;

        if (hash_count_reg == '0)
            used_probes = bfp_pkg::HASH_COUNT_W'(1);
        else if (hash_count_reg > bfp_pkg::HASH_COUNT_W'(bfp_pkg::MAX_PROBES))
            used_probes = bfp_pkg::HASH_COUNT_W'(bfp_pkg::MAX_PROBES);
        else
            used_probes = hash_count_reg;
    end

    // ---------------------------------------------------------------- datapath
    assign s_tready = (state_reg == S_IDLE) && !clear_busy;
    assign s_accept = s_tvalid && s_tready;

    assign mod_req.start    = s_accept;
    assign mod_req.dividend = s_tdata;
    assign mod_req.divisor  = used_bits;

    bfp_mod u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    assign mask      = 8'h80 >> bit_reg;
    assign bit_clear = (st_rdata & mask) == 8'h00;
    assign last      = ({1'b0, probe_index_reg} + 1'b1) >= used_probes;
    // the key-ending probe holds while the previous result is still pending
    assign advance   = !last || !m_tvalid_reg || m_tready;

    always_comb
    begin
        st_req.rd_en = 1'b0;
        st_req.wr_en = 1'b0;
        st_req.addr  = addr_reg;
        st_req.wdata = st_rdata | mask;
        if (state_reg == S_MOD && mod_rsp.done)
        begin
            st_req.rd_en = 1'b1;
            st_req.addr  = mod_rsp.remainder[bfp_pkg::BIT_IDX_W-1:3];
        end
        else if (state_reg == S_UPDATE && advance && op_reg == bfp_pkg::OP_INSERT)
        begin
            st_req.wr_en = 1'b1;
        end
    end

    bfp_store u_store
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (st_req),
        .rdata      (st_rdata),
        .clear_busy (clear_busy)
    );

    // ---------------------------------------------------------------- control
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (s_accept) state_next = S_MOD;
            S_MOD:    if (mod_rsp.done) state_next = S_UPDATE;
            S_UPDATE: if (advance) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            probe_index_reg <= '0;
            any_miss_reg    <= 1'b0;
            key_total_reg   <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (state_reg == S_UPDATE && advance)
            begin
                if (!last)
                begin
                    probe_index_reg <= probe_index_reg + 1'b1;
                    if (op_reg == bfp_pkg::OP_QUERY && bit_clear)
                    begin
                        any_miss_reg <= 1'b1;
                    end
                end
                else
                begin
                    probe_index_reg <= '0;
                    any_miss_reg    <= 1'b0;
                    m_tvalid_reg    <= 1'b1;
                    if (op_reg == bfp_pkg::OP_INSERT && key_total_reg != '1)
                    begin
                        key_total_reg <= key_total_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg <= s_tuser;
        end
        if (state_reg == S_MOD && mod_rsp.done)
        begin
            addr_reg <= mod_rsp.remainder[bfp_pkg::BIT_IDX_W-1:3];
            bit_reg  <= mod_rsp.remainder[2:0];
        end
        if (state_reg == S_UPDATE && advance && last)
        begin
            was_query_reg <= op_reg;
            found_reg     <= (op_reg == bfp_pkg::OP_QUERY) && !any_miss_reg && !bit_clear;
        end
    end

    // key_total only moves when a result is loaded, so it doubles as payload
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = was_query_reg;
    assign m_tdata  = bfp_pkg::OUT_DATA_W'({key_total_reg, found_reg});

endmodule

// ===== src/bfp_checker.sv =====
// ============================================================================
// bfp_checker - port-level checks of the bloom filter probe unit
// Watches the top level's channels and flags result and handshake slips.
// ============================================================================
module bfp_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [bfp_pkg::OUT_DATA_W-1:0]    m_tdata,
    input logic                              m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one probe in flight: no accept right after an accept
    a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("probe accepted while previous probe in flight");

    // an insert result never reports found
    a_insert_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> !m_tdata[0])
        else $error("insert result with found set");

    // padding above stored_keys stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[bfp_pkg::OUT_DATA_W-1:bfp_pkg::KEY_W+1] == '0)
        else $error("nonzero padding in result data");

    // a new result only follows an accepted probe
    a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !s_tready || $past(!s_tready))
        else $error("result appeared without a probe in flight");

endmodule

bind bloom_filter_probe_unit bfp_checker u_bfp_checker (.*);
